/* rtl/hbt_pkg.sv */
`timescale 1ns / 1ps

package hbt_pkg;

    localparam int TABLE_SLOTS_DEF = 2048;
    localparam int PROBE_LIMIT_DEF = 8;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int HASH_SHIFT_DEF  = 4;

    localparam int          WORD_W             = 32;
    localparam logic [31:0] HEADROOM_UNLIMITED = 32'h7FFF_FFFF;

    localparam logic FUNC_ALLOC      = 1'b0;
    localparam logic FUNC_PEAK_RESET = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LRD,
        ST_LCHK,
        ST_DECIDE,
        ST_IRD,
        ST_ICHK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic probe_old;
        logic probe_new;
        logic advance;
        logic mark_found;
        logic apply;
        logic ins_wr;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_peak;
        logic old_zero;
        logic hit;
        logic empty;
        logic probe_last;
        logic need_insert;
        logic out_busy;
    } status_t;

endpackage

/* rtl/hbt_ram.sv */
`timescale 1ns / 1ps

module hbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/hbt_ctrl.sv */
`timescale 1ns / 1ps

module hbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output hbt_pkg::cmd_t     cmd,
    input  hbt_pkg::status_t  sts
);

    hbt_pkg::state_t state_reg;
    hbt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbt_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = hbt_pkg::ST_IDLE;
                end
            end
            hbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hbt_pkg::ST_START;
                end
            end
            hbt_pkg::ST_START:
            begin
                if (sts.is_peak || sts.old_zero)
                begin
                    state_next = hbt_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = hbt_pkg::ST_LRD;
                end
            end
            hbt_pkg::ST_LRD:
            begin
                state_next = hbt_pkg::ST_LCHK;
            end
            hbt_pkg::ST_LCHK:
            begin
                if (sts.hit || sts.empty || sts.probe_last)
                begin
                    state_next = hbt_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = hbt_pkg::ST_LRD;
                end
            end
            hbt_pkg::ST_DECIDE:
            begin
                if (sts.need_insert)
                begin
                    state_next = hbt_pkg::ST_IRD;
                end
                else
                begin
                    state_next = hbt_pkg::ST_FIN;
                end
            end
            hbt_pkg::ST_IRD:
            begin
                state_next = hbt_pkg::ST_ICHK;
            end
            hbt_pkg::ST_ICHK:
            begin
                if (sts.empty || sts.probe_last)
                begin
                    state_next = hbt_pkg::ST_FIN;
                end
                else
                begin
                    state_next = hbt_pkg::ST_IRD;
                end
            end
            hbt_pkg::ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    state_next = hbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            hbt_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            hbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            hbt_pkg::ST_START:
            begin
                cmd.probe_old = 1'b1;
            end
            hbt_pkg::ST_LCHK:
            begin
                cmd.mark_found = sts.hit;
                cmd.advance    = !sts.hit && !sts.empty && !sts.probe_last;
            end
            hbt_pkg::ST_DECIDE:
            begin
                cmd.apply     = 1'b1;
                cmd.probe_new = sts.need_insert;
            end
            hbt_pkg::ST_ICHK:
            begin
                cmd.ins_wr  = sts.empty;
                cmd.advance = !sts.empty && !sts.probe_last;
            end
            hbt_pkg::ST_FIN:
            begin
                cmd.fin = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/hbt_dp.sv */
`timescale 1ns / 1ps

module hbt_dp #(
    parameter int TABLE_SLOTS = hbt_pkg::TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = hbt_pkg::PROBE_LIMIT_DEF,
    parameter int ADDR_BITS   = hbt_pkg::ADDR_BITS_DEF,
    parameter int HASH_SHIFT  = hbt_pkg::HASH_SHIFT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              func,
    input  logic [31:0]       old_addr,
    input  logic [31:0]       req_size,
    input  logic [31:0]       new_addr,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       result_addr,
    output logic              refused,
    output logic [31:0]       live_bytes,
    output logic [31:0]       peak_bytes,
    output logic [31:0]       largest_alloc,
    output logic [31:0]       refusal_count,
    output logic [31:0]       headroom,
    input  hbt_pkg::cmd_t     cmd,
    output hbt_pkg::status_t  sts
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int K_W   = $clog2(PROBE_LIMIT + 1);
    localparam int AW    = ADDR_BITS;
    localparam int ENT_W = AW + hbt_pkg::WORD_W;

    logic              func_reg;
    logic [AW-1:0]     old_reg;
    logic [31:0]       n_reg;
    logic [AW-1:0]     new_reg;
    logic              found_reg;
    logic [31:0]       osize_reg;
    logic [IDX_W-1:0]  fslot_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [K_W-1:0]    k_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [31:0]       budget_reg;
    logic [31:0]       live_reg;
    logic [31:0]       peak_reg;
    logic [31:0]       largest_reg;
    logic [31:0]       tally_reg;
    logic [AW-1:0]     res_reg;
    logic              refd_reg;
    logic              out_valid_reg;
    logic [31:0]       out_addr_reg;
    logic              out_refd_reg;
    logic [31:0]       out_live_reg;
    logic [31:0]       out_peak_reg;
    logic [31:0]       out_largest_reg;
    logic [31:0]       out_tally_reg;
    logic [31:0]       out_head_reg;

    logic [AW-1:0]     old_in;
    logic [AW-1:0]     new_in;
    logic [AW-1:0]     old_shift;
    logic [AW-1:0]     new_shift;
    logic [ENT_W-1:0]  rdata;
    logic [AW-1:0]     rd_addr;
    logic [31:0]       osize_eff;
    logic [33:0]       proj;
    logic [31:0]       live_new;
    logic              c_refuse;
    logic              c_free;
    logic              c_grow;
    logic              c_retarget;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [31:0]       head_val;

    assign old_in    = AW'(old_addr);
    assign new_in    = AW'(new_addr);
    assign old_shift = old_reg >> HASH_SHIFT;
    assign new_shift = new_reg >> HASH_SHIFT;
    assign rd_addr   = rdata[ENT_W-1:hbt_pkg::WORD_W];

    assign osize_eff = found_reg ? osize_reg : 32'd0;
    assign proj      = {2'b00, live_reg} + {2'b00, n_reg} - {2'b00, osize_eff};
    assign live_new  = proj[31:0];

    assign c_refuse   = (func_reg == hbt_pkg::FUNC_ALLOC) && (budget_reg != 32'd0)
                        && (n_reg != 32'd0)
                        && (proj[33] || (proj[32:0] > {1'b0, budget_reg}));
    assign c_free     = (func_reg == hbt_pkg::FUNC_ALLOC) && (n_reg == 32'd0);
    assign c_grow     = (func_reg == hbt_pkg::FUNC_ALLOC) && !c_refuse
                        && (n_reg != 32'd0) && (new_reg != '0);
    assign c_retarget = c_grow && (old_reg != '0) && found_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {new_reg, n_reg};
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (cmd.apply && c_free && found_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = fslot_reg;
            ram_wdata = '0;
        end
        else if (cmd.apply && c_retarget)
        begin
            ram_we    = 1'b1;
            ram_waddr = fslot_reg;
        end
        else if (cmd.ins_wr)
        begin
            ram_we = 1'b1;
        end
    end

    hbt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        if (budget_reg == 32'd0)
        begin
            head_val = hbt_pkg::HEADROOM_UNLIMITED;
        end
        else if (live_reg < budget_reg)
        begin
            head_val = budget_reg - live_reg;
        end
        else
        begin
            head_val = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            budget_reg    <= '0;
            live_reg      <= '0;
            peak_reg      <= '0;
            largest_reg   <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
            if (cmd.apply)
            begin
                if (func_reg == hbt_pkg::FUNC_PEAK_RESET)
                begin
                    peak_reg <= live_reg;
                end
                else if (c_refuse)
                begin
                    tally_reg <= tally_reg + 32'd1;
                end
                else if (c_free)
                begin
                    if (found_reg)
                    begin
                        live_reg <= live_reg - osize_reg;
                    end
                end
                else if (c_grow)
                begin
                    live_reg <= live_new;
                    if (live_new > peak_reg)
                    begin
                        peak_reg <= live_new;
                    end
                    if ((old_reg == '0) && (n_reg > largest_reg))
                    begin
                        largest_reg <= n_reg;
                    end
                end
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            old_reg   <= old_in;
            n_reg     <= req_size;
            new_reg   <= new_in;
            found_reg <= 1'b0;
        end
        if (cmd.probe_old)
        begin
            slot_reg <= old_shift[IDX_W-1:0];
            k_reg    <= '0;
        end
        else if (cmd.probe_new)
        begin
            slot_reg <= new_shift[IDX_W-1:0];
            k_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            slot_reg <= slot_reg + 1'b1;
            k_reg    <= k_reg + 1'b1;
        end
        if (cmd.mark_found)
        begin
            found_reg <= 1'b1;
            fslot_reg <= slot_reg;
            osize_reg <= rdata[31:0];
        end
        if (cmd.apply)
        begin
            res_reg  <= c_grow ? new_reg : '0;
            refd_reg <= c_refuse;
        end
        if (cmd.fin)
        begin
            out_addr_reg    <= 32'(res_reg);
            out_refd_reg    <= refd_reg;
            out_live_reg    <= live_reg;
            out_peak_reg    <= peak_reg;
            out_largest_reg <= largest_reg;
            out_tally_reg   <= tally_reg;
            out_head_reg    <= head_val;
        end
    end

    assign sts.clr_last    = (clr_reg == {IDX_W{1'b1}});
    assign sts.is_peak     = (func_reg == hbt_pkg::FUNC_PEAK_RESET);
    assign sts.old_zero    = (old_reg == '0);
    assign sts.hit         = (rd_addr == old_reg);
    assign sts.empty       = (rd_addr == '0);
    assign sts.probe_last  = (k_reg == K_W'(PROBE_LIMIT - 1));
    assign sts.need_insert = c_grow && !c_retarget;
    assign sts.out_busy    = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign result_addr   = out_addr_reg;
    assign refused       = out_refd_reg;
    assign live_bytes    = out_live_reg;
    assign peak_bytes    = out_peak_reg;
    assign largest_alloc = out_largest_reg;
    assign refusal_count = out_tally_reg;
    assign headroom      = out_head_reg;

endmodule

/* rtl/heap_budget_tracker.sv */
`timescale 1ns / 1ps
// sequence: a peak reset skips both probe walks, a fresh allocation skips the lookup walk,
//   and each probe walk (lookup of old_addr, insert at new_addr) visits up to PROBE_LIMIT slots
// flow: one transfer at a time, each table probe is a registered read followed by a check
// reset: counters and budget clear; the table is then swept to empty, one slot per cycle,
//   and in_ready stays low until the sweep ends

module heap_budget_tracker #(
    parameter int TABLE_SLOTS = hbt_pkg::TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = hbt_pkg::PROBE_LIMIT_DEF,
    parameter int ADDR_BITS   = hbt_pkg::ADDR_BITS_DEF,
    parameter int HASH_SHIFT  = hbt_pkg::HASH_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] old_addr,
    input  logic [31:0] req_size,
    input  logic [31:0] new_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_addr,
    output logic        refused,
    output logic [31:0] live_bytes,
    output logic [31:0] peak_bytes,
    output logic [31:0] largest_alloc,
    output logic [31:0] refusal_count,
    output logic [31:0] headroom
);

    hbt_pkg::cmd_t    cmd;
    hbt_pkg::status_t sts;

    hbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    hbt_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .PROBE_LIMIT (PROBE_LIMIT),
        .ADDR_BITS   (ADDR_BITS),
        .HASH_SHIFT  (HASH_SHIFT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .old_addr      (old_addr),
        .req_size      (req_size),
        .new_addr      (new_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_addr   (result_addr),
        .refused       (refused),
        .live_bytes    (live_bytes),
        .peak_bytes    (peak_bytes),
        .largest_alloc (largest_alloc),
        .refusal_count (refusal_count),
        .headroom      (headroom),
        .cmd           (cmd),
        .sts           (sts)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while an item is in progress");

    a_refused_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refused |-> result_addr == 32'd0)
        else $error("refused request reports an address");

    a_single_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clr_step, cmd.apply, cmd.ins_wr}) <= 1)
        else $error("conflicting table write commands");

endmodule
